/* src/pac_pkg.sv */
package pac_pkg;

  localparam int unsigned AddrHalfW = 64;
  localparam int unsigned KeyW = 48;

  localparam logic [47:0] OnionPfx = 48'hfd87_d87e_eb43;
  localparam logic [63:0] Nat64Hi = 64'h0064_ff9b_0000_0000;
  localparam logic [63:0] LinkLocalHi = 64'hfe80_0000_0000_0000;
  localparam logic [63:0] ShiftHi = 64'h0000_0000_0000_00ff;
  localparam logic [31:0] MappedLo = 32'h0000_ffff;
  localparam logic [31:0] TranslatedLo = 32'hffff_0000;
  localparam logic [15:0] Pfx2001 = 16'h2001;
  localparam logic [15:0] Pfx2002 = 16'h2002;
  localparam logic [15:0] DocsWord = 16'h0db8;
  localparam logic [15:0] HeWord = 16'h0470;
  localparam logic [6:0] UlaTop = 7'b1111110;
  localparam logic [7:0] LowNibbleOnes = 8'h0f;
  localparam logic [7:0] KeyTypeLocal = 8'd255;
  localparam logic [7:0] KeyTypeV4 = 8'd4;
  localparam logic [7:0] KeyTypeV6 = 8'd6;
  localparam logic [7:0] KeyTypeOnion = 8'd8;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_V4     = 3'd1,
    CLS_V6     = 3'd2,
    CLS_ONION  = 3'd3,
    CLS_TEREDO = 3'd4
  } net_e;

  typedef enum logic [2:0] {
    REACH_UNREACHABLE = 3'd0,
    REACH_DEFAULT     = 3'd1,
    REACH_TEREDO      = 3'd2,
    REACH_IPV6_WEAK   = 3'd3,
    REACH_IPV4        = 3'd4,
    REACH_IPV6_STRONG = 3'd5,
    REACH_PRIVATE     = 3'd6
  } reach_e;

  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_LOCAL  = 3'd1,
    KEY_V4     = 3'd2,
    KEY_6TO4   = 3'd3,
    KEY_TEREDO = 3'd4,
    KEY_ONION  = 3'd5,
    KEY_V6     = 3'd6
  } key_e;

  typedef struct packed {
    logic v4;
    logic onion;
    logic zero16;
    logic loop6;
    logic nat64;
    logic linklocal;
    logic translated;
    logic shift;
    logic p2001;
    logic sixto4;
    logic b23zero;
    logic docs;
    logic orchid;
    logic he470;
    logic ula;
    logic v4zero;
    logic v4bcast;
    logic v4priv;
    logic v4loc;
  } flags_t;

  // address bytes that the group key can pick up
  typedef struct packed {
    logic [39:0] b0to4;
    logic [7:0]  b6;
    logic [15:0] b12to13;
  } key_bytes_t;

  typedef struct packed {
    flags_t     addr;
    flags_t     peer;
    key_bytes_t bytes;
  } stage1_t;

  typedef struct packed {
    logic       valid;
    logic       routable;
    logic       host_local;
    net_e       net;
    logic       teredo;
  } class_t;

  typedef struct packed {
    class_t     addr;
    net_e       peer_net;
    logic       tunnel;
    key_e       key_kind;
    logic       he470;
    key_bytes_t bytes;
  } stage2_t;

  function automatic flags_t decode_flags(logic [AddrHalfW-1:0] hi, logic [AddrHalfW-1:0] lo);
    flags_t f;
    logic [7:0] o1;
    logic [7:0] o2;
    logic [7:0] o3;
    o1 = lo[31:24];
    o2 = lo[23:16];
    o3 = lo[15:8];
    f.v4         = (hi == '0) && (lo[63:32] == MappedLo);
    f.onion      = (hi[63:16] == OnionPfx);
    f.zero16     = (hi == '0) && (lo == '0);
    f.loop6      = (hi == '0) && (lo == 64'd1);
    f.nat64      = (hi == Nat64Hi) && (lo[63:32] == '0);
    f.linklocal  = (hi == LinkLocalHi);
    f.translated = (hi == '0) && (lo[63:32] == TranslatedLo);
    f.shift      = (hi == ShiftHi) && (lo[63:56] == 8'hff);
    f.p2001      = (hi[63:48] == Pfx2001);
    f.sixto4     = (hi[63:48] == Pfx2002);
    f.b23zero    = (hi[47:32] == '0);
    f.docs       = (hi[47:32] == DocsWord);
    f.orchid     = (hi[47:40] == '0) && ((hi[39:36] == 4'h1) || (hi[39:36] == 4'h2));
    f.he470      = (hi[47:32] == HeWord);
    f.ula        = (hi[63:57] == UlaTop);
    f.v4zero     = (lo[31:0] == '0);
    f.v4bcast    = (lo[31:0] == '1);
    f.v4loc      = (o1 == 8'd127) || (o1 == 8'd0);
    f.v4priv     = (o1 == 8'd10) ||
                   ((o1 == 8'd192) && (o2 == 8'd168)) ||
                   ((o1 == 8'd172) && (o2[7:4] == 4'h1)) ||
                   ((o1 == 8'd198) && (o2[7:1] == 7'd9)) ||
                   ((o1 == 8'd169) && (o2 == 8'd254)) ||
                   ((o1 == 8'd100) && (o2[7:6] == 2'b01)) ||
                   ((o1 == 8'd192) && (o2 == 8'd0) && (o3 == 8'd2)) ||
                   ((o1 == 8'd198) && (o2 == 8'd51) && (o3 == 8'd100)) ||
                   ((o1 == 8'd203) && (o2 == 8'd0) && (o3 == 8'd113));
    return f;
  endfunction

  function automatic class_t classify(flags_t f);
    class_t c;
    logic   is_null;
    is_null      = f.v4 ? f.v4zero : f.zero16;
    c.valid      = !f.shift && !is_null && !(f.v4 && f.v4bcast) && !(f.p2001 && f.docs);
    c.host_local = f.v4 ? f.v4loc : f.loop6;
    c.routable   = c.valid && !(f.v4 && f.v4priv) && !f.linklocal &&
                   !(f.ula && !f.onion) && !(f.p2001 && f.orchid) && !c.host_local;
    c.teredo     = f.p2001 && f.b23zero;
    if (!c.routable) begin
      c.net = CLS_NONE;
    end else if (f.v4) begin
      c.net = CLS_V4;
    end else if (c.teredo) begin
      c.net = CLS_TEREDO;
    end else if (f.onion) begin
      c.net = CLS_ONION;
    end else begin
      c.net = CLS_V6;
    end
    return c;
  endfunction

endpackage

/* src/pac_decode.sv */
module pac_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [63:0]          addr_high_i,
  input  logic [63:0]          addr_low_i,
  input  logic [63:0]          peer_high_i,
  input  logic [63:0]          peer_low_i,
  output logic                 valid_o,
  output pac_pkg::stage1_t     s1_o
);
  import pac_pkg::*;

  logic    valid_q;
  stage1_t s1_d, s1_q;

  always_comb begin
    s1_d.addr          = decode_flags(addr_high_i, addr_low_i);
    s1_d.peer          = decode_flags(peer_high_i, peer_low_i);
    s1_d.bytes.b0to4   = addr_high_i[63:24];
    s1_d.bytes.b6      = addr_high_i[15:8];
    s1_d.bytes.b12to13 = addr_low_i[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

/* src/pac_class.sv */
module pac_class (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  pac_pkg::stage1_t     s1_i,
  output logic                 valid_o,
  output pac_pkg::stage2_t     s2_o
);
  import pac_pkg::*;

  logic    valid_q;
  stage2_t s2_d, s2_q;
  class_t  ac;
  class_t  pc;

  always_comb begin
    ac = classify(s1_i.addr);
    pc = classify(s1_i.peer);
    s2_d.addr     = ac;
    s2_d.peer_net = pc.net;
    s2_d.tunnel   = s1_i.addr.sixto4 || s1_i.addr.nat64 || s1_i.addr.translated;
    s2_d.he470    = s1_i.addr.p2001 && s1_i.addr.he470;
    s2_d.bytes    = s1_i.bytes;
    // group key rule, in priority order
    if (ac.host_local) begin
      s2_d.key_kind = KEY_LOCAL;
    end else if (!ac.routable) begin
      s2_d.key_kind = KEY_NONE;
    end else if (s1_i.addr.v4 || s1_i.addr.translated || s1_i.addr.nat64) begin
      s2_d.key_kind = KEY_V4;
    end else if (s1_i.addr.sixto4) begin
      s2_d.key_kind = KEY_6TO4;
    end else if (ac.teredo) begin
      s2_d.key_kind = KEY_TEREDO;
    end else if (s1_i.addr.onion) begin
      s2_d.key_kind = KEY_ONION;
    end else begin
      s2_d.key_kind = KEY_V6;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

/* src/pac_result.sv */
module pac_result (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  pac_pkg::stage2_t     s2_i,
  output logic                 valid_o,
  output logic                 is_valid_o,
  output logic                 is_routable_o,
  output logic                 is_local_o,
  output logic [2:0]           net_class_o,
  output logic [47:0]          group_key_o,
  output logic [2:0]           reach_code_o
);
  import pac_pkg::*;

  logic            valid_q;
  logic            is_valid_q, is_routable_q, is_local_q;
  net_e            net_q;
  logic [KeyW-1:0] key_d, key_q;
  reach_e          reach_d, reach_q;
  logic [7:0]      b0, b1, b2, b3, b4, b6, b12, b13;

  function automatic reach_e reach_of(logic rout, net_e sn, net_e dn, logic tunnel);
    reach_e r;
    r = REACH_DEFAULT;
    if (!rout) begin
      r = REACH_UNREACHABLE;
    end else begin
      case (dn)
        CLS_V4: begin
          r = (sn == CLS_V4) ? REACH_IPV4 : REACH_DEFAULT;
        end
        CLS_V6: begin
          if (sn == CLS_TEREDO) r = REACH_TEREDO;
          else if (sn == CLS_V4) r = REACH_IPV4;
          else if (sn == CLS_V6) r = tunnel ? REACH_IPV6_WEAK : REACH_IPV6_STRONG;
        end
        CLS_ONION: begin
          if (sn == CLS_V4) r = REACH_IPV4;
          else if (sn == CLS_ONION) r = REACH_PRIVATE;
        end
        CLS_TEREDO: begin
          if (sn == CLS_TEREDO) r = REACH_TEREDO;
          else if (sn == CLS_V6) r = REACH_IPV6_WEAK;
          else if (sn == CLS_V4) r = REACH_IPV4;
        end
        default: begin
          if (sn == CLS_TEREDO) r = REACH_TEREDO;
          else if (sn == CLS_V6) r = REACH_IPV6_WEAK;
          else if (sn == CLS_V4) r = REACH_IPV4;
          else if (sn == CLS_ONION) r = REACH_PRIVATE;
        end
      endcase
    end
    return r;
  endfunction

  assign b0  = s2_i.bytes.b0to4[39:32];
  assign b1  = s2_i.bytes.b0to4[31:24];
  assign b2  = s2_i.bytes.b0to4[23:16];
  assign b3  = s2_i.bytes.b0to4[15:8];
  assign b4  = s2_i.bytes.b0to4[7:0];
  assign b6  = s2_i.bytes.b6;
  assign b12 = s2_i.bytes.b12to13[15:8];
  assign b13 = s2_i.bytes.b12to13[7:0];

  always_comb begin
    case (s2_i.key_kind)
      KEY_LOCAL:  key_d = {KeyTypeLocal, 40'd0};
      KEY_V4:     key_d = {KeyTypeV4, b12, b13, 24'd0};
      KEY_6TO4:   key_d = {KeyTypeV4, b2, b3, 24'd0};
      KEY_TEREDO: key_d = {KeyTypeV4, ~b12, ~b13, 24'd0};
      KEY_ONION:  key_d = {KeyTypeOnion, b6 | LowNibbleOnes, 32'd0};
      KEY_V6: begin
        key_d = {KeyTypeV6, b0, b1, b2, b3, s2_i.he470 ? (b4 | LowNibbleOnes) : 8'd0};
      end
      default:    key_d = '0;
    endcase
    reach_d = reach_of(s2_i.addr.routable, s2_i.addr.net, s2_i.peer_net, s2_i.tunnel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      is_valid_q    <= s2_i.addr.valid;
      is_routable_q <= s2_i.addr.routable;
      is_local_q    <= s2_i.addr.host_local;
      net_q         <= s2_i.addr.net;
      key_q         <= key_d;
      reach_q       <= reach_d;
    end
  end

  assign valid_o       = valid_q;
  assign is_valid_o    = is_valid_q;
  assign is_routable_o = is_routable_q;
  assign is_local_o    = is_local_q;
  assign net_class_o   = net_q;
  assign group_key_o   = key_q;
  assign reach_code_o  = reach_q;

endmodule

/* src/peer_address_classifier_top.sv */
// peer address classifier
// input channel: in_valid_i / in_ready_o with an address pair, each address as
// two 64-bit big-endian halves (ipv4 in mapped form)
// output channel: out_valid_o / out_ready_i with validity, routability,
// locality, network class, 48-bit group key and reach code of the address
// toward the peer
// three register stages: prefix decode of both addresses, classification and
// key rule select, then key assembly and reach code into the output register
// an accepted item moves through the decode, class and result registers in turn,
// and out_valid_o shows it from the result register; one item per cycle is taken and
// delivered as long as out_ready_i stays high
// each stage moves when it is empty or the stage after it moves, so a stalled
// receiver fills the empty stages first and only then drops in_ready_o
// reset clears the stage valid bits; payload registers keep whatever they hold
// and no item is shown until a new one is accepted
module peer_address_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [63:0] peer_high_i,
  input  logic [63:0] peer_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_valid_o,
  output logic        is_routable_o,
  output logic        is_local_o,
  output logic [2:0]  net_class_o,
  output logic [47:0] group_key_o,
  output logic [2:0]  reach_code_o
);
  import pac_pkg::*;

  logic    v1, v2, v3;
  logic    en1, en2, en3;
  stage1_t s1;
  stage2_t s2;

  assign en3        = !v3 || out_ready_i;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign in_ready_o = en1;
  assign out_valid_o = v3;

  pac_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en1),
    .valid_i     (in_valid_i),
    .addr_high_i (addr_high_i),
    .addr_low_i  (addr_low_i),
    .peer_high_i (peer_high_i),
    .peer_low_i  (peer_low_i),
    .valid_o     (v1),
    .s1_o        (s1)
  );

  pac_class u_class (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .s1_i    (s1),
    .valid_o (v2),
    .s2_o    (s2)
  );

  pac_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en3),
    .valid_i       (v2),
    .s2_i          (s2),
    .valid_o       (v3),
    .is_valid_o    (is_valid_o),
    .is_routable_o (is_routable_o),
    .is_local_o    (is_local_o),
    .net_class_o   (net_class_o),
    .group_key_o   (group_key_o),
    .reach_code_o  (reach_code_o)
  );

endmodule

/* sim/pac_result_checker.sv */
`timescale 1ns / 100ps

module pac_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [63:0] peer_high_i,
  input  logic [63:0] peer_low_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        is_valid_i,
  input  logic        is_routable_i,
  input  logic        is_local_i,
  input  logic [2:0]  net_class_i,
  input  logic [47:0] group_key_i,
  input  logic [2:0]  reach_code_i,
  output int          errors_o,
  output int          pending_o
);
  import pac_pkg::*;

  localparam logic [95:0] MappedPrefix    = 96'h0000_0000_0000_0000_0000_ffff;
  localparam logic [95:0] Nat64Prefix     = 96'h0064_ff9b_0000_0000_0000_0000;
  localparam logic [95:0] XlatPrefix      = 96'h0000_0000_0000_0000_ffff_0000;
  localparam logic [71:0] ShiftPrefix     = 72'h0000_0000_0000_00ff_ff;
  localparam logic [63:0] LinkLocalPrefix = 64'hfe80_0000_0000_0000;
  localparam logic [47:0] OnionPrefix     = 48'hfd87_d87e_eb43;
  localparam int unsigned MaxReports = 40;

  // byte 0 of the address is element 0, the most significant byte
  typedef logic [0:15][7:0] addr_t;

  typedef struct packed {
    logic valid;
    logic routable;
    logic host_local;
    net_e net;
  } addr_class_t;

  typedef struct packed {
    addr_class_t cls;
    logic [47:0] key;
    reach_e      reach;
  } verdict_t;

  verdict_t    verdict_q[$];
  verdict_t    want;
  int unsigned reports;

  function automatic logic is_mapped(addr_t a);
    return a[0:11] == MappedPrefix;
  endfunction

  function automatic logic is_onion(addr_t a);
    return a[0:5] == OnionPrefix;
  endfunction

  // 6to4, nat64 and translated forms carry an embedded ipv4 address
  function automatic logic is_tunnel(addr_t a);
    return a[0:1] == 16'h2002 || a[0:11] == Nat64Prefix || a[0:11] == XlatPrefix;
  endfunction

  function automatic addr_class_t classify_addr(addr_t a);
    addr_class_t c;
    logic        mapped;
    logic        p2001;
    logic        nul;
    logic        priv;
    logic [7:0]  o1;
    logic [7:0]  o2;
    logic [7:0]  o3;
    mapped = is_mapped(a);
    p2001  = a[0:1] == 16'h2001;
    o1     = a[12];
    o2     = a[13];
    o3     = a[14];
    nul    = mapped ? (a[12:15] == '0) : (a == '0);
    priv   = mapped && (o1 == 8'd10 ||
                        (o1 == 8'd192 && o2 == 8'd168) ||
                        (o1 == 8'd172 && o2 >= 8'd16 && o2 <= 8'd31) ||
                        (o1 == 8'd198 && (o2 == 8'd18 || o2 == 8'd19)) ||
                        (o1 == 8'd169 && o2 == 8'd254) ||
                        (o1 == 8'd100 && o2 >= 8'd64 && o2 <= 8'd127) ||
                        (o1 == 8'd192 && o2 == 8'd0 && o3 == 8'd2) ||
                        (o1 == 8'd198 && o2 == 8'd51 && o3 == 8'd100) ||
                        (o1 == 8'd203 && o2 == 8'd0 && o3 == 8'd113));
    c.host_local = mapped ? (o1 == 8'd127 || o1 == 8'd0) : (a == 128'd1);
    c.valid = !(a[0:8] == ShiftPrefix) && !nul &&
              !(mapped && a[12:15] == 32'hffff_ffff) &&
              !(p2001 && a[2:3] == 16'h0db8);
    c.routable = c.valid && !priv && !(a[0:7] == LinkLocalPrefix) &&
                 !((a[0] & 8'hfe) == 8'hfc && !is_onion(a)) &&
                 !(p2001 && a[2] == 8'h00 && (a[3][7:4] == 4'h1 || a[3][7:4] == 4'h2)) &&
                 !c.host_local;
    if (!c.routable) begin
      c.net = CLS_NONE;
    end else if (mapped) begin
      c.net = CLS_V4;
    end else if (p2001 && a[2:3] == 16'h0000) begin
      c.net = CLS_TEREDO;
    end else if (is_onion(a)) begin
      c.net = CLS_ONION;
    end else begin
      c.net = CLS_V6;
    end
    return c;
  endfunction

  function automatic logic [47:0] group_key_of(addr_t a, addr_class_t c);
    logic [0:5][7:0] k;
    k = '0;
    if (c.host_local) begin
      k[0] = KeyTypeLocal;
    end else if (!c.routable) begin
      k = '0;
    end else if (is_mapped(a) || a[0:11] == XlatPrefix || a[0:11] == Nat64Prefix) begin
      k[0:2] = {KeyTypeV4, a[12], a[13]};
    end else if (a[0:1] == 16'h2002) begin
      k[0:2] = {KeyTypeV4, a[2], a[3]};
    end else if (c.net == CLS_TEREDO) begin
      k[0:2] = {KeyTypeV4, ~a[12], ~a[13]};
    end else if (is_onion(a)) begin
      k[0:1] = {KeyTypeOnion, a[6] | 8'h0f};
    end else begin
      k[0:4] = {KeyTypeV6, a[0], a[1], a[2], a[3]};
      // this tunnel broker range also keys on the next nibble
      if (a[0:3] == 32'h2001_0470) k[5] = a[4] | 8'h0f;
    end
    return k;
  endfunction

  function automatic reach_e reach_of(addr_t a, addr_class_t ac, net_e peer_net);
    reach_e r;
    net_e   an;
    an = ac.net;
    r  = REACH_DEFAULT;
    if (!ac.routable) begin
      r = REACH_UNREACHABLE;
    end else begin
      case (peer_net)
        CLS_V4: begin
          if (an == CLS_V4) r = REACH_IPV4;
        end
        CLS_V6: begin
          if (an == CLS_TEREDO) r = REACH_TEREDO;
          else if (an == CLS_V4) r = REACH_IPV4;
          else if (an == CLS_V6) r = is_tunnel(a) ? REACH_IPV6_WEAK : REACH_IPV6_STRONG;
        end
        CLS_ONION: begin
          if (an == CLS_V4) r = REACH_IPV4;
          else if (an == CLS_ONION) r = REACH_PRIVATE;
        end
        CLS_TEREDO: begin
          if (an == CLS_TEREDO) r = REACH_TEREDO;
          else if (an == CLS_V6) r = REACH_IPV6_WEAK;
          else if (an == CLS_V4) r = REACH_IPV4;
        end
        default: begin
          if (an == CLS_TEREDO) r = REACH_TEREDO;
          else if (an == CLS_V6) r = REACH_IPV6_WEAK;
          else if (an == CLS_V4) r = REACH_IPV4;
          else if (an == CLS_ONION) r = REACH_PRIVATE;
        end
      endcase
    end
    return r;
  endfunction

  function automatic verdict_t classify_pair(logic [63:0] ah, logic [63:0] al,
                                             logic [63:0] ph, logic [63:0] pl);
    verdict_t    v;
    addr_t       a;
    addr_t       p;
    addr_class_t pc;
    a       = {ah, al};
    p       = {ph, pl};
    v.cls   = classify_addr(a);
    pc      = classify_addr(p);
    v.key   = group_key_of(a, v.cls);
    v.reach = reach_of(a, v.cls, pc.net);
    return v;
  endfunction

  task automatic check_field(input string what, input logic [47:0] exp_v,
                             input logic [47:0] got_v);
    if (exp_v !== got_v) begin
      errors_o++;
      if (reports < MaxReports) begin
        reports++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
      end
    end
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
    reports   = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        verdict_q.push_back(classify_pair(addr_high_i, addr_low_i, peer_high_i, peer_low_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          errors_o++;
          if (reports < MaxReports) begin
            reports++;
            $display("%0t: result with nothing expected, expected none, got key %0h",
                     $time, group_key_i);
          end
        end else begin
          want = verdict_q.pop_front();
          check_field("is_valid", 48'(want.cls.valid), 48'(is_valid_i));
          check_field("is_routable", 48'(want.cls.routable), 48'(is_routable_i));
          check_field("is_local", 48'(want.cls.host_local), 48'(is_local_i));
          check_field("net_class", 48'(want.cls.net), 48'(net_class_i));
          check_field("group_key", want.key, group_key_i);
          check_field("reach_code", 48'(want.reach), 48'(reach_code_i));
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

/* sim/tb_peer_address_classifier_top.sv */
`timescale 1ns / 100ps

module tb_peer_address_classifier_top;

  localparam int PhaseItems = 406;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] addr_high_i = '0;
  logic [63:0] addr_low_i = '0;
  logic [63:0] peer_high_i = '0;
  logic [63:0] peer_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        is_valid_o;
  logic        is_routable_o;
  logic        is_local_o;
  logic [2:0]  net_class_o;
  logic [47:0] group_key_o;
  logic [2:0]  reach_code_o;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;

  // sender idle / receiver stall percentages per phase
  int idle_by_phase[4] = '{0, 77, 0, 23};
  int stall_by_phase[4] = '{0, 0, 77, 23};

  peer_address_classifier_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .addr_high_i  (addr_high_i),
    .addr_low_i   (addr_low_i),
    .peer_high_i  (peer_high_i),
    .peer_low_i   (peer_low_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_valid_o   (is_valid_o),
    .is_routable_o(is_routable_o),
    .is_local_o   (is_local_o),
    .net_class_o  (net_class_o),
    .group_key_o  (group_key_o),
    .reach_code_o (reach_code_o)
  );

  pac_result_checker classifier_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .addr_high_i  (addr_high_i),
    .addr_low_i   (addr_low_i),
    .peer_high_i  (peer_high_i),
    .peer_low_i   (peer_low_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_valid_i   (is_valid_o),
    .is_routable_i(is_routable_o),
    .is_local_i   (is_local_o),
    .net_class_i  (net_class_o),
    .group_key_i  (group_key_o),
    .reach_code_i (reach_code_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // random address, weighted toward the special ranges and their borders
  function automatic logic [127:0] pick_address();
    logic [127:0] x;
    logic [7:0]   o1;
    logic [7:0]   o2;
    logic [7:0]   o3;
    logic [7:0]   o4;
    x  = {$urandom, $urandom, $urandom, $urandom};
    o1 = 8'($urandom);
    o2 = 8'($urandom);
    o3 = 8'($urandom);
    o4 = 8'($urandom);
    case ($urandom_range(15))
      0: ;
      1: begin
        x[127:32] = 96'h0000_0000_0000_0000_0000_ffff;
        // near miss on the mapped prefix
        if ($urandom_range(3) == 0) x[127:32] = x[127:32] ^ (96'd1 << $urandom_range(95));
      end
      2, 3: begin
        x[127:32] = 96'h0000_0000_0000_0000_0000_ffff;
        case ($urandom_range(13))
          0: o1 = 8'd10;
          1: {o1, o2} = {8'd192, 8'd168};
          2: begin o1 = 8'd172; o2 = 8'($urandom_range(14, 33)); end
          3: begin o1 = 8'd198; o2 = 8'($urandom_range(17, 20)); end
          4: {o1, o2} = {8'd169, 8'd254};
          5: begin o1 = 8'd100; o2 = 8'($urandom_range(60, 131)); end
          6: {o1, o2, o3} = {8'd192, 8'd0, 8'd2};
          7: {o1, o2, o3} = {8'd198, 8'd51, 8'd100};
          8: {o1, o2, o3} = {8'd203, 8'd0, 8'd113};
          9: o1 = 8'd127;
          10: begin
            o1 = 8'd0;
            if ($urandom_range(1)) {o2, o3, o4} = '0;
          end
          11: {o1, o2, o3, o4} = 32'hffff_ffff;
          12: begin
            o1 = 8'd255;
            if ($urandom_range(1)) {o2, o3} = 16'hffff;
          end
          default: ;
        endcase
        x[31:0] = {o1, o2, o3, o4};
      end
      4: x[127:80] = 48'hfd87_d87e_eb43;
      5: x[127:96] = 32'h2001_0000;
      6: begin
        x[127:112] = 16'h2001;
        case ($urandom_range(3))
          0: x[111:96] = 16'h0db8;
          1: x[111:96] = 16'h0470;
          2: x[111:96] = 16'($urandom_range(16'h0000, 16'h0040));
          default: ;
        endcase
      end
      7: x[127:112] = 16'h2002;
      8: x[127:32] = 96'h0064_ff9b_0000_0000_0000_0000;
      9: x[127:32] = 96'h0000_0000_0000_0000_ffff_0000;
      10: x[127:64] = 64'hfe80_0000_0000_0000;
      11: begin
        x[127:121] = 7'b1111110;
        if ($urandom_range(1)) x[127:80] = 48'hfd87_d87e_eb43 ^ (48'd1 << $urandom_range(47));
      end
      12: x[127:56] = 72'h0000_0000_0000_00ff_ff;
      13: begin
        x[127:64] = '0;
        if ($urandom_range(1)) x = 128'($urandom_range(3));
      end
      default: x[127:125] = 3'b001;
    endcase
    return x;
  endfunction

  task automatic send_pair(input logic [127:0] addr, input logic [127:0] peer);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    addr_high_i <= addr[127:64];
    addr_low_i  <= addr[63:0];
    peer_high_i <= peer[127:64];
    peer_low_i  <= peer[63:0];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // extremes of the fields
    send_pair('0, '0);
    send_pair('1, '1);
    // shifted form, null, broadcast, documentation
    send_pair(128'h0000_0000_0000_00ff_ff12_3456_789a_bcde, 128'h2a00_0000_0000_0000_0000_0000_0000_0001);
    send_pair(128'h0000_0000_0000_0000_0000_ffff_0000_0000, 128'h0000_0000_0000_0000_0000_ffff_0808_0808);
    send_pair(128'h0000_0000_0000_0000_0000_ffff_ffff_ffff, 128'h0000_0000_0000_0000_0000_ffff_0808_0808);
    send_pair(128'h2001_0db8_0000_0000_0000_0000_0000_0001, 128'h2a00_0000_0000_0000_0000_0000_0000_0001);
    // loopback and zero-net locals
    send_pair(128'h0000_0000_0000_0000_0000_0000_0000_0001, '0);
    send_pair(128'h0000_0000_0000_0000_0000_ffff_7f00_0001, '0);
    send_pair(128'h0000_0000_0000_0000_0000_ffff_0001_0203, '0);
    // private ipv4, then public ipv4 toward an ipv4, an onion and an unroutable peer
    send_pair(128'h0000_0000_0000_0000_0000_ffff_0a01_0203, 128'h0000_0000_0000_0000_0000_ffff_0808_0808);
    send_pair(128'h0000_0000_0000_0000_0000_ffff_0808_0808, 128'h0000_0000_0000_0000_0000_ffff_0101_0101);
    send_pair(128'h0000_0000_0000_0000_0000_ffff_0808_0808, 128'hfd87_d87e_eb43_1234_5678_0000_0000_0001);
    send_pair(128'h0000_0000_0000_0000_0000_ffff_0808_0808, 128'h0000_0000_0000_0000_0000_ffff_c0a8_0101);
    // teredo, orchid, link-local, unique local
    send_pair(128'h2001_0000_4136_e378_8000_63bf_3fff_fdd2, 128'h2a00_0000_0000_0000_0000_0000_0000_0001);
    send_pair(128'h2001_0010_0000_0000_0000_0000_0000_0001, '1);
    send_pair(128'hfe80_0000_0000_0000_0000_0000_0000_0001, '1);
    send_pair(128'hfc00_0000_0000_0000_0000_0000_0000_0001, '1);
    // onion toward onion and toward ipv4
    send_pair(128'hfd87_d87e_eb43_1234_5678_9abc_def0_0001, 128'hfd87_d87e_eb43_0000_0000_0000_0000_0002);
    send_pair(128'hfd87_d87e_eb43_1234_5678_9abc_def0_0001, 128'h0000_0000_0000_0000_0000_ffff_0808_0808);
    // embedded ipv4 forms toward ipv6, the translated one toward teredo
    send_pair(128'h2002_0102_0304_0000_0000_0000_0000_0001, 128'h2a00_0000_0000_0000_0000_0000_0000_0001);
    send_pair(128'h0064_ff9b_0000_0000_0000_0000_0102_0304, 128'h2a00_0000_0000_0000_0000_0000_0000_0001);
    send_pair(128'h0000_0000_0000_0000_ffff_0000_0102_0304, 128'h2001_0000_4136_e378_8000_63bf_3fff_fdd2);
    // tunnel broker range, plain ipv6 toward ipv6 and teredo
    send_pair(128'h2001_0470_abcd_1234_0000_0000_0000_0001, 128'h2a00_0000_0000_0000_0000_0000_0000_0001);
    send_pair(128'h2a00_1450_4001_0800_0000_0000_0000_200e, 128'h2a00_0000_0000_0000_0000_0000_0000_0001);
    send_pair(128'h2a00_1450_4001_0800_0000_0000_0000_200e, 128'h2001_0000_4136_e378_8000_63bf_3fff_fdd2);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      repeat (PhaseItems) send_pair(pick_address(), pick_address());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
